// File: hdl/http_chunked_body_decoder_macros.svh
// ----------------------------------------------------------------------------
// http chunked body decoder assertion macros
// shared concurrent assertion forms, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// same-cycle implication
`define HCBD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// types, codes and character classes for the chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // width of the chunk-size accumulator, 32 to 64
  localparam int unsigned SizeBits = 64;

  localparam int unsigned CfgIdxBits  = 1;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [CfgIdxBits-1:0] CfgMaxBody   = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgMaxHeader = 1'b1;

  localparam logic [31:0] MaxBodyReset   = 32'd16777216;
  localparam logic [15:0] MaxHeaderReset = 16'd8192;

  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrMalformed = 3'd1;
  localparam logic [2:0] ErrMetadata  = 3'd2;
  localparam logic [2:0] ErrBody      = 3'd3;
  localparam logic [2:0] ErrLost      = 3'd4;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDel   = 8'h7f;

  typedef enum logic [1:0] {
    OpData  = 2'd0,
    OpClose = 2'd1,
    OpStart = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhSize    = 4'd1,
    PhExt     = 4'd2,
    PhData    = 4'd3,
    PhDataCr  = 4'd4,
    PhDataLf  = 4'd5,
    PhTrailer = 4'd6,
    PhDone    = 4'd7,
    PhError   = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    ExName0  = 3'd0,
    ExName   = 3'd1,
    ExVal0   = 3'd2,
    ExTokVal = 3'd3,
    ExQuoted = 3'd4,
    ExEscape = 3'd5,
    ExClosed = 3'd6,
    ExBad    = 3'd7
  } ext_e;

  typedef struct packed {
    logic ok;
    logic [3:0] val;
  } hex_t;

  // chunk-size line parse state
  typedef struct packed {
    logic in_size;
    ext_e ext;
    logic [SizeBits-1:0] acc;
    logic ovf;
    logic digits;
  } line_st_t;

  function automatic logic token_char(logic [7:0] c);
    logic r;
    r = 1'b0;
    if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
      r = 1'b1;
    end
    // 8'h60 is the grave accent
    case (c)
      "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", 8'h60, "|", "~": r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic hex_t hex_value(logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= "0" && c <= "9") begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= "a" && c <= "f") begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end else if (c >= "A" && c <= "F") begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end
    return h;
  endfunction

  // one ordinary byte of a chunk-size line
  function automatic line_st_t line_byte(line_st_t s, logic [7:0] c);
    line_st_t r;
    hex_t h;
    r = s;
    h = hex_value(c);
    if (s.in_size) begin
      if (h.ok) begin
        if (s.acc[SizeBits-1 -: 4] != 4'd0) begin
          r.ovf = 1'b1;
        end
        r.acc    = {s.acc[SizeBits-5:0], h.val};
        r.digits = 1'b1;
      end else begin
        r.in_size = 1'b0;
        r.ext     = (c == ChSemi) ? ExName0 : ExBad;
      end
    end else begin
      case (s.ext)
        ExName0: r.ext = token_char(c) ? ExName : ExBad;
        ExName: begin
          if (c == ChSemi) r.ext = ExName0;
          else if (c == ChEq) r.ext = ExVal0;
          else if (!token_char(c)) r.ext = ExBad;
        end
        ExVal0: begin
          if (c == ChQuote) r.ext = ExQuoted;
          else r.ext = token_char(c) ? ExTokVal : ExBad;
        end
        ExTokVal: begin
          if (c == ChSemi) r.ext = ExName0;
          else if (!token_char(c)) r.ext = ExBad;
        end
        ExQuoted: begin
          if (c == ChQuote) r.ext = ExClosed;
          else if (c == ChBslash) r.ext = ExEscape;
          else if (c < ChSpace || c == ChDel) r.ext = ExBad;
        end
        ExEscape: r.ext = ExQuoted;
        ExClosed: r.ext = (c == ChSemi) ? ExName0 : ExBad;
        default:  r.ext = ExBad;
      endcase
    end
    return r;
  endfunction

endpackage

// File: hdl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// byte-serial decoder for a chunked http/1.1 message body
// ----------------------------------------------------------------------------
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata: data_byte, tuser: op
// m_axis    out  m_axis_tvalid/tready    tdata: body_byte, complete, error_code
//                                        tuser: body_valid
// cfg       in   cfg_valid/cfg_ready     cfg_addr: register index, cfg_data
//
// one request in, one result out, a new request every cycle while m_axis drains the results
// result shows on m_axis in the cycle after the input request is taken
// the single output register sets the rate: input is taken while it is empty
//   or being drained in the same cycle
// asynchronous active-low reset returns limits to their defaults, phase idle
// cfg_ready is always high
//
module http_chunked_body_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]                       s_axis_tuser,   // [1:0] op
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,   // [7:0] body_byte, [8] complete,
                                                           // [11:9] error_code, [15:12] zero
  output logic                             m_axis_tuser,   // [0] body_valid
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hcbd_pkg::CfgIdxBits-1:0]  cfg_addr,
  input  logic [hcbd_pkg::CfgDataBits-1:0] cfg_data
);

  // limits
  logic [31:0] max_body_q;
  logic [15:0] max_hdr_q;

  // decoder state
  hcbd_pkg::phase_e            phase_q, phase_d;
  hcbd_pkg::ext_e              ext_q, ext_d;
  logic [hcbd_pkg::SizeBits-1:0] acc_q, acc_d;
  logic                        ovf_q, ovf_d;
  logic                        digits_q, digits_d;
  logic [31:0]                 chunk_rem_q, chunk_rem_d;
  logic [31:0]                 body_cnt_q, body_cnt_d;
  logic [15:0]                 meta_q, meta_d;
  logic                        prev_cr_q, prev_cr_d;
  logic [1:0]                  term_q, term_d;
  logic [2:0]                  err_q, err_d;

  // output register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_bv_q;
  logic        out_cmp_q;
  logic [2:0]  out_err_q;

  logic        in_fire;
  logic [7:0]  c;
  logic [1:0]  op;
  logic [15:0] meta_inc;
  logic        ext_ok;
  logic [31:0] room;
  logic        trl_done;
  logic [7:0]  body_d;
  logic        bv_d;
  hcbd_pkg::line_st_t ls, lb;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cfg_ready     = 1'b1;
  assign c             = s_axis_tdata;
  assign op            = s_axis_tuser;

  // saturating metadata count
  assign meta_inc = (meta_q != 16'hffff) ? meta_q + 16'd1 : meta_q;

  // only these extension states may end a size line
  assign ext_ok = (phase_q == hcbd_pkg::PhSize) || (ext_q == hcbd_pkg::ExName) ||
                  (ext_q == hcbd_pkg::ExTokVal) || (ext_q == hcbd_pkg::ExClosed);

  // body bytes still allowed
  assign room = (max_body_q > body_cnt_q) ? max_body_q - body_cnt_q : 32'd0;

  assign ls = '{in_size: (phase_q == hcbd_pkg::PhSize), ext: ext_q, acc: acc_q,
                ovf: ovf_q, digits: digits_q};

  always_comb begin
    phase_d     = phase_q;
    ext_d       = ext_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    digits_d    = digits_q;
    chunk_rem_d = chunk_rem_q;
    body_cnt_d  = body_cnt_q;
    meta_d      = meta_q;
    prev_cr_d   = prev_cr_q;
    term_d      = term_q;
    err_d       = err_q;
    body_d      = 8'd0;
    bv_d        = 1'b0;
    lb          = ls;
    trl_done    = 1'b0;

    case (op)
      hcbd_pkg::OpStart: begin
        ext_d       = hcbd_pkg::ExName0;
        acc_d       = '0;
        ovf_d       = 1'b0;
        digits_d    = 1'b0;
        meta_d      = 16'd0;
        prev_cr_d   = 1'b0;
        chunk_rem_d = 32'd0;
        body_cnt_d  = 32'd0;
        term_d      = 2'd0;
        err_d       = hcbd_pkg::ErrNone;
        phase_d     = hcbd_pkg::PhSize;
      end
      hcbd_pkg::OpClose: begin
        if (phase_q >= hcbd_pkg::PhSize && phase_q <= hcbd_pkg::PhTrailer) begin
          phase_d = hcbd_pkg::PhError;
          err_d   = hcbd_pkg::ErrLost;
        end
      end
      hcbd_pkg::OpData: begin
        case (phase_q)
          hcbd_pkg::PhSize, hcbd_pkg::PhExt: begin
            if (prev_cr_q && c == hcbd_pkg::ChLf) begin
              // line complete: check it and pick the next phase
              prev_cr_d = 1'b0;
              meta_d    = 16'd0;
              if (!digits_q || ovf_q || !ext_ok) begin
                phase_d = hcbd_pkg::PhError;
                err_d   = hcbd_pkg::ErrMalformed;
              end else if (acc_q == '0) begin
                phase_d = hcbd_pkg::PhTrailer;
                term_d  = 2'd0;
              end else if (acc_q > hcbd_pkg::SizeBits'(room)) begin
                phase_d = hcbd_pkg::PhError;
                err_d   = hcbd_pkg::ErrBody;
              end else begin
                chunk_rem_d = acc_q[31:0];
                phase_d     = hcbd_pkg::PhData;
              end
            end else begin
              // a pending cr not followed by lf is an ordinary line byte
              if (prev_cr_q) begin
                lb = hcbd_pkg::line_byte(lb, hcbd_pkg::ChCr);
              end
              prev_cr_d = 1'b0;
              if (c == hcbd_pkg::ChLf) begin
                phase_d = hcbd_pkg::PhError;
                err_d   = hcbd_pkg::ErrMalformed;
              end else begin
                meta_d = meta_inc;
                if (c == hcbd_pkg::ChCr) begin
                  prev_cr_d = 1'b1;
                end else begin
                  lb = hcbd_pkg::line_byte(lb, c);
                end
                phase_d  = lb.in_size ? hcbd_pkg::PhSize : hcbd_pkg::PhExt;
                ext_d    = lb.ext;
                acc_d    = lb.acc;
                ovf_d    = lb.ovf;
                digits_d = lb.digits;
                if (meta_inc >= max_hdr_q) begin
                  phase_d = hcbd_pkg::PhError;
                  err_d   = hcbd_pkg::ErrMetadata;
                end
              end
            end
          end
          hcbd_pkg::PhData: begin
            body_d      = c;
            bv_d        = 1'b1;
            body_cnt_d  = body_cnt_q + 32'd1;
            chunk_rem_d = chunk_rem_q - 32'd1;
            if (chunk_rem_q == 32'd1) begin
              phase_d = hcbd_pkg::PhDataCr;
            end
          end
          hcbd_pkg::PhDataCr: begin
            if (c == hcbd_pkg::ChCr) begin
              phase_d = hcbd_pkg::PhDataLf;
            end else begin
              phase_d = hcbd_pkg::PhError;
              err_d   = hcbd_pkg::ErrMalformed;
            end
          end
          hcbd_pkg::PhDataLf: begin
            if (c == hcbd_pkg::ChLf) begin
              ext_d     = hcbd_pkg::ExName0;
              acc_d     = '0;
              ovf_d     = 1'b0;
              digits_d  = 1'b0;
              meta_d    = 16'd0;
              prev_cr_d = 1'b0;
              phase_d   = hcbd_pkg::PhSize;
            end else begin
              phase_d = hcbd_pkg::PhError;
              err_d   = hcbd_pkg::ErrMalformed;
            end
          end
          hcbd_pkg::PhTrailer: begin
            // term: 1 after cr, 2 after crlf, 3 after crlfcr
            meta_d = meta_inc;
            if (c == hcbd_pkg::ChLf) begin
              if (term_q == 2'd1) begin
                if (meta_inc == 16'd2) trl_done = 1'b1;
                else term_d = 2'd2;
              end else if (term_q == 2'd3) begin
                trl_done = 1'b1;
              end else begin
                phase_d = hcbd_pkg::PhError;
                err_d   = hcbd_pkg::ErrMalformed;
              end
            end else if (c == hcbd_pkg::ChCr) begin
              term_d = (term_q == 2'd2) ? 2'd3 : 2'd1;
            end else begin
              term_d = 2'd0;
            end
            if (phase_d != hcbd_pkg::PhError) begin
              if (trl_done) begin
                if (meta_inc > max_hdr_q) begin
                  phase_d = hcbd_pkg::PhError;
                  err_d   = hcbd_pkg::ErrMetadata;
                end else begin
                  phase_d = hcbd_pkg::PhDone;
                end
              end else if (meta_inc >= max_hdr_q) begin
                phase_d = hcbd_pkg::PhError;
                err_d   = hcbd_pkg::ErrMetadata;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= hcbd_pkg::MaxBodyReset;
      max_hdr_q  <= hcbd_pkg::MaxHeaderReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        hcbd_pkg::CfgMaxBody:   max_body_q <= cfg_data[31:0];
        hcbd_pkg::CfgMaxHeader: max_hdr_q  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hcbd_pkg::PhIdle;
      ext_q       <= hcbd_pkg::ExName0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      digits_q    <= 1'b0;
      chunk_rem_q <= 32'd0;
      body_cnt_q  <= 32'd0;
      meta_q      <= 16'd0;
      prev_cr_q   <= 1'b0;
      term_q      <= 2'd0;
      err_q       <= hcbd_pkg::ErrNone;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      ext_q       <= ext_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      digits_q    <= digits_d;
      chunk_rem_q <= chunk_rem_d;
      body_cnt_q  <= body_cnt_d;
      meta_q      <= meta_d;
      prev_cr_q   <= prev_cr_d;
      term_q      <= term_d;
      err_q       <= err_d;
    end
  end

  // result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register: payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_byte_q <= body_d;
      out_bv_q   <= bv_d;
      out_cmp_q  <= (phase_d == hcbd_pkg::PhDone);
      out_err_q  <= (phase_d == hcbd_pkg::PhError) ? err_d : hcbd_pkg::ErrNone;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_err_q, out_cmp_q, out_byte_q};
  assign m_axis_tuser  = out_bv_q;

  `include "http_chunked_body_decoder_macros.svh"

  // a payload byte never comes with a status
  `HCBD_ASSERT_IMPL(a_body_no_status, out_valid_q && out_bv_q,
                    !out_cmp_q && out_err_q == hcbd_pkg::ErrNone, "body byte with status")
  // in the data phase at least one payload byte is still owed
  `HCBD_ASSERT_IMPL(a_data_rem_nonzero, phase_q == hcbd_pkg::PhData,
                    chunk_rem_q != 32'd0, "empty chunk in data phase")
  // every accepted request leaves a result
  `HCBD_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid_q, "request without result")

endmodule

// File: bench/http_chunked_body_decoder_checker.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_checker
// tracks the decoder's state on every input request and compares each result
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_checker
  import hcbd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic                   req_ready_i,
  input  logic [7:0]             req_byte_i,
  input  logic [1:0]             req_op_i,
  input  logic                   res_valid_i,
  input  logic                   res_ready_i,
  input  logic [15:0]            res_data_i,
  input  logic                   res_body_valid_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CfgIdxBits-1:0]  cfg_addr_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output int unsigned            mismatches_o,
  output int unsigned            outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    logic       complete;
    logic [2:0] error_code;
  } decode_out_t;

  decode_out_t decoder_outputs_q[$];
  int unsigned miss_cnt = 0;
  int unsigned outstanding = 0;

  // shadow of the decoder state
  phase_e              ph;
  ext_e                ext;
  logic [SizeBits-1:0] size_acc;
  logic                size_ovf;
  logic                saw_digit;
  logic [31:0]         chunk_left;
  logic [31:0]         body_total;
  logic [15:0]         meta_len;
  logic                cr_held;
  logic [1:0]          term_state;
  logic [2:0]          err_held;
  logic [31:0]         lim_body;
  logic [15:0]         lim_meta;

  assign mismatches_o  = miss_cnt;
  assign outstanding_o = outstanding;

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
    miss_cnt++;
  endtask

  function automatic logic is_tchar(logic [7:0] c);
    if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
      return 1'b1;
    case (c)
      "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", 8'h60, "|", "~": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // {is hex digit, value}
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  task automatic abort_with(logic [2:0] code);
    err_held = code;
    ph       = PhError;
  endtask

  task automatic restart_line();
    ext       = ExName0;
    size_acc  = '0;
    size_ovf  = 1'b0;
    saw_digit = 1'b0;
    meta_len  = '0;
    cr_held   = 1'b0;
  endtask

  // ordinary byte of a size line: hex digits, then the extension grammar
  task automatic take_line_char(logic [7:0] c);
    logic [4:0] h;
    h = hex_nibble(c);
    if (ph == PhSize) begin
      if (h[4]) begin
        if ((size_acc >> (SizeBits - 4)) != '0) size_ovf = 1'b1;
        size_acc  = (size_acc << 4) | SizeBits'(h[3:0]);
        saw_digit = 1'b1;
      end else begin
        ph  = PhExt;
        ext = (c == ChSemi) ? ExName0 : ExBad;
      end
      return;
    end
    case (ext)
      ExName0: ext = is_tchar(c) ? ExName : ExBad;
      ExName: begin
        if (c == ChSemi) ext = ExName0;
        else if (c == ChEq) ext = ExVal0;
        else if (!is_tchar(c)) ext = ExBad;
      end
      ExVal0: begin
        if (c == ChQuote) ext = ExQuoted;
        else ext = is_tchar(c) ? ExTokVal : ExBad;
      end
      ExTokVal: begin
        if (c == ChSemi) ext = ExName0;
        else if (!is_tchar(c)) ext = ExBad;
      end
      ExQuoted: begin
        if (c == ChQuote) ext = ExClosed;
        else if (c == ChBslash) ext = ExEscape;
        else if (c < ChSpace || c == ChDel) ext = ExBad;
      end
      ExEscape: ext = ExQuoted;
      ExClosed: ext = (c == ChSemi) ? ExName0 : ExBad;
      default:  ext = ExBad;
    endcase
  endtask

  task automatic take_size_line(logic [7:0] c);
    logic [31:0] room;
    logic        line_ok;
    if (cr_held) begin
      cr_held = 1'b0;
      if (c == ChLf) begin
        line_ok  = saw_digit && !size_ovf &&
                   (ph == PhSize || ext == ExName || ext == ExTokVal || ext == ExClosed);
        meta_len = '0;
        if (!line_ok) begin
          abort_with(ErrMalformed);
        end else if (size_acc == '0) begin
          ph         = PhTrailer;
          term_state = 2'd0;
        end else begin
          room = (lim_body > body_total) ? lim_body - body_total : 32'd0;
          if (size_acc > room) begin
            abort_with(ErrBody);
          end else begin
            chunk_left = size_acc[31:0];
            ph         = PhData;
          end
        end
        return;
      end
      // lone cr is just another line byte
      take_line_char(ChCr);
    end
    if (c == ChLf) begin
      abort_with(ErrMalformed);
      return;
    end
    if (meta_len != 16'hffff) meta_len++;
    if (c == ChCr) cr_held = 1'b1;
    else take_line_char(c);
    if (meta_len >= lim_meta) abort_with(ErrMetadata);
  endtask

  // trailer section ends at a leading crlf or at crlf crlf
  task automatic take_trailer(logic [7:0] c);
    logic finished;
    finished = 1'b0;
    if (meta_len != 16'hffff) meta_len++;
    if (c == ChLf) begin
      if (term_state == 2'd1) begin
        if (meta_len == 16'd2) finished = 1'b1;
        else term_state = 2'd2;
      end else if (term_state == 2'd3) begin
        finished = 1'b1;
      end else begin
        abort_with(ErrMalformed);
        return;
      end
    end else if (c == ChCr) begin
      term_state = (term_state == 2'd2) ? 2'd3 : 2'd1;
    end else begin
      term_state = 2'd0;
    end
    if (finished) begin
      if (meta_len > lim_meta) abort_with(ErrMetadata);
      else ph = PhDone;
    end else if (meta_len >= lim_meta) begin
      abort_with(ErrMetadata);
    end
  endtask

  task automatic decode_request(logic [1:0] op, logic [7:0] c, output decode_out_t r);
    r = '0;
    case (op)
      OpStart: begin
        restart_line();
        chunk_left = '0;
        body_total = '0;
        term_state = 2'd0;
        err_held   = ErrNone;
        ph         = PhSize;
      end
      OpClose: begin
        if (ph >= PhSize && ph <= PhTrailer) abort_with(ErrLost);
      end
      OpData: begin
        case (ph)
          PhSize, PhExt: take_size_line(c);
          PhData: begin
            r.body_byte  = c;
            r.body_valid = 1'b1;
            body_total++;
            chunk_left--;
            if (chunk_left == '0) ph = PhDataCr;
          end
          PhDataCr: begin
            if (c == ChCr) ph = PhDataLf;
            else abort_with(ErrMalformed);
          end
          PhDataLf: begin
            if (c == ChLf) begin
              restart_line();
              ph = PhSize;
            end else begin
              abort_with(ErrMalformed);
            end
          end
          PhTrailer: take_trailer(c);
          default: ;
        endcase
      end
      default: ;
    endcase
    r.complete   = (ph == PhDone);
    r.error_code = (ph == PhError) ? err_held : ErrNone;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    decode_out_t want;
    decode_out_t next_out;
    if (!rst_ni) begin
      ph         = PhIdle;
      restart_line();
      chunk_left = '0;
      body_total = '0;
      term_state = 2'd0;
      err_held   = ErrNone;
      lim_body   = MaxBodyReset;
      lim_meta   = MaxHeaderReset;
      decoder_outputs_q.delete();
      outstanding = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (decoder_outputs_q.size() == 0) begin
          report_mismatch("result with no request pending", 0, res_data_i);
        end else begin
          want = decoder_outputs_q.pop_front();
          if (res_data_i[7:0] !== want.body_byte)
            report_mismatch("body_byte", want.body_byte, res_data_i[7:0]);
          if (res_body_valid_i !== want.body_valid)
            report_mismatch("body_valid", want.body_valid, res_body_valid_i);
          if (res_data_i[8] !== want.complete)
            report_mismatch("complete", want.complete, res_data_i[8]);
          if (res_data_i[11:9] !== want.error_code)
            report_mismatch("error_code", want.error_code, res_data_i[11:9]);
          if (res_data_i[15:12] !== 4'd0)
            report_mismatch("reserved bits", 0, res_data_i[15:12]);
        end
      end
      // a request taken at this edge still sees the old limits
      if (req_valid_i && req_ready_i) begin
        decode_request(req_op_i, req_byte_i, next_out);
        decoder_outputs_q.push_back(next_out);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          CfgMaxBody:   lim_body = cfg_data_i[31:0];
          CfgMaxHeader: lim_meta = cfg_data_i[15:0];
          default: ;
        endcase
      end
      outstanding = decoder_outputs_q.size();
    end
  end

endmodule

// File: bench/http_chunked_body_decoder_test.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_test
// drives chunked bodies, mostly well formed with random corruption, through
// the decoder under several limit settings and idle patterns
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hcbd_pkg::*;

  // op code the decoder does not use: must leave the state alone
  localparam logic [1:0] OpSpare = 2'd3;
  localparam logic [7:0] ChColon = ":";

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] b;
  } req_t;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   s_valid   = 1'b0;
  logic                   s_ready;
  logic [7:0]             s_data    = '0;
  logic [1:0]             s_op      = '0;
  logic                   m_valid;
  logic                   m_ready   = 1'b0;
  logic [15:0]            m_data;
  logic                   m_body_valid;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxBits-1:0]  cfg_addr  = '0;
  logic [CfgDataBits-1:0] cfg_data  = '0;

  int unsigned mismatch_cnt;
  int unsigned pending;

  // idle percentages, changed per phase by the stimulus
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent_cnt       = 0;

  req_t  plan[$];
  string tchars = "!#$%&'*+-.^_|~0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  http_chunked_body_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_op),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_body_valid),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  http_chunked_body_decoder_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (s_valid),
    .req_ready_i      (s_ready),
    .req_byte_i       (s_data),
    .req_op_i         (s_op),
    .res_valid_i      (m_valid),
    .res_ready_i      (m_ready),
    .res_data_i       (m_data),
    .res_body_valid_i (m_body_valid),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_addr_i       (cfg_addr),
    .cfg_data_i       (cfg_data),
    .mismatches_o     (mismatch_cnt),
    .outstanding_o    (pending)
  );

  // result side back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one input request; valid stays up across back-to-back requests so it is
  // only lowered inside an idle gap
  task automatic push_request(logic [1:0] op, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_op    <= op;
    s_data  <= b;
    do @(posedge clk_i); while (!s_ready);
    sent_cnt++;
  endtask

  // stop sending and let every outstanding result come back
  task automatic hold_until_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---- request plan builders ----

  task automatic add_req(logic [1:0] op, logic [7:0] b);
    plan.push_back(req_t'{op: op, b: b});
  endtask

  task automatic add_byte(logic [7:0] b);
    add_req(OpData, b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_crlf();
    add_byte(ChCr);
    add_byte(ChLf);
  endtask

  // hex digits from the most significant one, mixed letter case
  task automatic add_hex_value(logic [63:0] v, int unsigned digits);
    logic [3:0] nib;
    for (int i = digits; i > 0; i--) begin
      nib = 4'(v >> (4 * (i - 1)));
      if (nib < 4'd10) add_byte("0" + nib);
      else if ($urandom_range(1) != 0) add_byte("a" + nib - 8'd10);
      else add_byte("A" + nib - 8'd10);
    end
  endtask

  task automatic add_token();
    repeat ($urandom_range(4, 1)) add_byte(tchars[$urandom_range(tchars.len() - 1)]);
  endtask

  // quoted string: printable text, high bytes, backslash escapes of any byte
  task automatic add_quoted();
    int unsigned roll;
    logic [7:0]  b;
    add_byte(ChQuote);
    repeat ($urandom_range(6)) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        b = 8'($urandom_range(8'h7e, 8'h20));
        add_byte((b == ChQuote || b == ChBslash) ? ChSpace : b);
      end else if (roll < 85) begin
        add_byte(8'($urandom_range(8'hff, 8'h80)));
      end else begin
        // escaped cr is the one stray cr that the line accepts
        add_byte(ChBslash);
        add_byte(($urandom_range(3) == 0) ? ChCr : 8'($urandom));
      end
    end
    add_byte(ChQuote);
  endtask

  task automatic add_extension();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return;
    add_byte(ChSemi);
    add_token();
    if (roll < 65) begin
      // bare name
    end else if (roll < 75) begin
      add_byte(ChEq);
      add_token();
    end else if (roll < 87) begin
      add_byte(ChEq);
      add_quoted();
    end else if (roll < 93) begin
      add_byte(ChSemi);
      add_token();
      add_byte(ChEq);
      if ($urandom_range(1) != 0) add_quoted();
      else add_token();
    end else begin
      // broken extensions
      case ($urandom_range(5))
        0: add_byte(ChSpace);
        1: add_byte(ChEq);
        2: begin
          add_byte(ChEq);
          add_byte(ChQuote);
          add_token();
        end
        3: begin
          add_byte(ChEq);
          add_byte(ChQuote);
          add_byte(($urandom_range(1) != 0) ? ChDel : 8'($urandom_range(31)));
          add_byte(ChQuote);
        end
        4: begin
          add_byte(ChEq);
          add_quoted();
          add_token();
        end
        default: add_byte(ChSemi);
      endcase
    end
  endtask

  // one chunked body, usually opened by a start request
  task automatic compose_body();
    int unsigned roll;
    int unsigned len;
    logic [63:0] wide;
    plan.delete();
    if ($urandom_range(19) != 0) add_req(OpStart, 8'($urandom));
    repeat ($urandom_range(3)) begin
      roll = $urandom_range(99);
      wide = {$urandom, $urandom};
      if (roll < 80) begin
        len = $urandom_range(20, 1);
        add_hex_value(64'(len), ((len > 15) ? 2 : 1) + $urandom_range(2));
        add_extension();
        add_crlf();
        repeat (len) add_byte(8'($urandom));
        add_crlf();
      end else begin
        // size lines that end the body early: too big, overflowing, empty
        if (roll < 88) begin
          wide[63] = 1'b1;
          len = $urandom_range(16, 9);
          add_hex_value(wide >> (4 * (16 - len)), len);
        end else if (roll < 93) begin
          add_hex_value(64'($urandom_range(15, 1)), 1);
          add_hex_value(wide, 16);
        end else if (roll >= 96) begin
          add_hex_value(64'(wide[31:0]), 8);
        end
        add_extension();
        add_crlf();
        repeat ($urandom_range(4)) add_byte(8'($urandom));
        return;
      end
    end
    // last chunk and trailer section
    add_hex_value(64'd0, $urandom_range(3, 1));
    add_extension();
    add_crlf();
    repeat ($urandom_range(2)) begin
      add_token();
      add_byte(ChColon);
      add_byte(ChSpace);
      repeat ($urandom_range(6)) add_byte(8'($urandom_range(8'h7e, 8'h21)));
      add_crlf();
    end
    add_crlf();
  endtask

  task automatic send_plan();
    foreach (plan[i]) push_request(plan[i].op, plan[i].b);
  endtask

  // break some bodies: flipped byte, bare lf, stray cr, early close,
  // truncation or an unused op slipped in
  task automatic corrupt_and_send();
    int unsigned roll;
    int unsigned cut;
    roll = $urandom_range(99);
    cut  = $urandom_range(plan.size() - 1, 1);
    if (roll < 6) begin
      plan[cut].b = 8'($urandom);
    end else if (roll < 10) begin
      plan.insert(cut, req_t'{op: OpData, b: ChLf});
    end else if (roll < 13) begin
      plan.insert(cut, req_t'{op: OpData, b: ChCr});
    end else if (roll < 16) begin
      plan.insert(cut, req_t'{op: OpClose, b: 8'($urandom)});
    end else if (roll < 19) begin
      while (plan.size() > cut) void'(plan.pop_back());
    end else if (roll < 21) begin
      plan.insert(cut, req_t'{op: OpSpare, b: 8'($urandom)});
    end
    send_plan();
  endtask

  // limit settings, one per segment
  task automatic apply_limits(int unsigned seg);
    case (seg)
      0: begin
        write_limit(CfgMaxBody, 32'hffff_ffff);
        write_limit(CfgMaxHeader, 32'h0000_ffff);
      end
      1: begin
        write_limit(CfgMaxHeader, 32'h0000_0001);
        write_limit(CfgMaxBody, 32'h0000_0000);
      end
      2: begin
        write_limit(CfgMaxBody, 32'h0000_0000);
        write_limit(CfgMaxHeader, {16'($urandom), MaxHeaderReset});
      end
      3: begin
        write_limit(CfgMaxBody, 32'($urandom_range(120, 8)));
        write_limit(CfgMaxHeader, {16'($urandom), 16'($urandom_range(40, 4))});
      end
      default: begin
        write_limit(CfgMaxBody, MaxBodyReset);
        write_limit(CfgMaxHeader, {16'($urandom), MaxHeaderReset});
      end
    endcase
  endtask

  initial begin : stimulus
    int unsigned send_pct [4];
    int unsigned recv_pct [4];
    int unsigned target;
    send_pct = '{0, 57, 0, 34};
    recv_pct = '{0, 0, 57, 34};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle handling, a small clean body, completion, bare lf, close
    plan.delete();
    add_req(OpSpare, 8'hff);    // unused op while idle
    add_req(OpData, 8'h00);     // byte before any start is dropped
    add_req(OpClose, 8'h5a);    // close while idle is ignored
    add_req(OpStart, 8'h00);
    add_text("2;a");
    add_crlf();
    add_byte(8'h00);
    add_byte(8'hff);
    add_crlf();
    add_text("0");
    add_crlf();
    add_crlf();
    add_req(OpData, 8'h41);     // after completion, dropped
    add_req(OpClose, 8'h00);    // close after completion is ignored
    add_req(OpStart, 8'h00);
    add_byte(ChLf);             // bare lf on the size line
    add_req(OpStart, 8'h00);
    add_text("1");
    add_req(OpClose, 8'h00);    // peer closes mid-line
    send_plan();

    // random part: each idle pattern runs through every limit setting;
    // limits are only written once the decoder has drained
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      for (int seg = 0; seg < 5; seg++) begin
        hold_until_drained();
        apply_limits(seg);
        target = sent_cnt + ((seg == 1) ? 20 : (seg == 2) ? 50 : 90);
        while (sent_cnt < target) begin
          if ($urandom_range(99) < 5) begin
            push_request(2'($urandom), 8'($urandom));
          end else begin
            compose_body();
            corrupt_and_send();
          end
        end
      end
    end

    hold_until_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: http_chunked_body_decoder.f
+incdir+hdl
hdl/hcbd_pkg.sv
hdl/http_chunked_body_decoder.sv
bench/http_chunked_body_decoder_checker.sv
bench/http_chunked_body_decoder_test.sv
